### rtl/core/mirp_pkg.sv
// shared types and constants for the mirror image reflection point block
`timescale 1ns / 1ps
`default_nettype none

package mirp_pkg;

  // request fields, one candidate per request
  typedef struct packed {
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [31:0] ear_x;
    logic signed [31:0] ear_y;
    logic signed [31:0] ear_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
  } req_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [31:0] path_length;
  } res_t;

  localparam logic [15:0] EPS_RESET = 16'd66;

  // quotient bits of the side ratio, root bits of the path length
  localparam int DIV_STEPS  = 17;
  localparam int ROOT_STEPS = 32;

  // stage numbers counted from the accepting edge
  localparam int ST_DIV_OUT = 4 + DIV_STEPS;
  localparam int ST_POINT   = ST_DIV_OUT + 6;
  localparam int ST_PATH    = 11 + ROOT_STEPS + 1;
  localparam int LATENCY    = ST_PATH + 1;

endpackage

`default_nettype wire

### rtl/core/mirp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module mirp_div (
  input  logic        clk,
  input  logic [48:0] num,
  input  logic [49:0] den,
  output logic [16:0] quo
);
  import mirp_pkg::*;

  logic [49:0] rem_q [DIV_STEPS];
  logic [49:0] den_q [DIV_STEPS];
  logic [16:0] quo_q [DIV_STEPS];
  logic [49:0] rem_n [DIV_STEPS];
  logic [16:0] quo_n [DIV_STEPS];

  always_comb begin
    logic [50:0] r2;
    logic [49:0] rp;
    logic [49:0] dp;
    logic [16:0] qp;
    logic        ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        rp = {1'b0, num};
        dp = den;
        qp = '0;
      end else begin
        rp = rem_q[k-1];
        dp = den_q[k-1];
        qp = quo_q[k-1];
      end
      r2 = {rp, 1'b0};
      ge = (r2 >= {1'b0, dp});
      // remainder stays below the divisor
      rem_n[k] = ge ? 50'(r2 - {1'b0, dp}) : r2[49:0];
      quo_n[k] = {qp[15:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_q[k] <= rem_n[k];
      quo_q[k] <= quo_n[k];
      den_q[k] <= (k == 0) ? den : den_q[k-1];
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/mirp_sqrt.sv
// pipelined square root, one root bit per stage, then round and saturate
`timescale 1ns / 1ps
`default_nettype none

module mirp_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  input  logic        sat,
  output logic [31:0] root
);
  import mirp_pkg::*;

  logic [63:0] x_q   [ROOT_STEPS];
  logic [32:0] rem_q [ROOT_STEPS];
  logic [31:0] rt_q  [ROOT_STEPS];
  logic        sat_q [ROOT_STEPS];
  logic [32:0] rem_n [ROOT_STEPS];
  logic [31:0] rt_n  [ROOT_STEPS];
  logic [32:0] rounded;

  always_comb begin
    logic [63:0] xp;
    logic [32:0] remp;
    logic [31:0] rtp;
    logic [34:0] trial;
    logic [34:0] sub;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (k == 0) begin
        xp   = rad;
        remp = '0;
        rtp  = '0;
      end else begin
        xp   = x_q[k-1];
        remp = rem_q[k-1];
        rtp  = rt_q[k-1];
      end
      trial = {remp, xp[63:62]};
      sub   = {1'b0, rtp, 2'b01};
      if (trial >= sub) begin
        rem_n[k] = 33'(trial - sub);
        rt_n[k]  = {rtp[30:0], 1'b1};
      end else begin
        rem_n[k] = trial[32:0];
        rt_n[k]  = {rtp[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rem_q[k] <= rem_n[k];
      rt_q[k]  <= rt_n[k];
      x_q[k]   <= (k == 0) ? {rad[61:0], 2'b00} : {x_q[k-1][61:0], 2'b00};
      sat_q[k] <= (k == 0) ? sat : sat_q[k-1];
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  assign rounded = {1'b0, rt_q[ROOT_STEPS-1]}
                 + {32'd0, (rem_q[ROOT_STEPS-1] > {1'b0, rt_q[ROOT_STEPS-1]})};

  always_ff @(posedge clk) begin
    root <= (sat_q[ROOT_STEPS-1] || rounded[32]) ? 32'hFFFF_FFFF : rounded[31:0];
  end

endmodule

`default_nettype wire

### rtl/core/mirror_image_reflection_point.sv
// top level: image source reflection point and path length pipeline
//
// usage
//   a request is taken on every rising edge with start high and busy low; busy
//   is always low, so a new candidate may enter every cycle
//   each request gives exactly one result: done is high for one cycle with res
//   holding valid_res, the reflection point and the image to listener length
//   throughput is one request per cycle
//   the latency is set by the path length root (32 stages, one root bit each)
//   behind the plane distance, image and square stages; the 17 stage side
//   ratio divider runs alongside it
//   side_epsilon is written through cfg_we / cfg_wdata; write it only while no
//   request is in flight, the block does not enforce this; it resets to 66
//   a synchronous reset drops every request in flight and clears done
//   the receiver cannot stall, so results are never held back
`timescale 1ns / 1ps
`default_nettype none

module mirror_image_reflection_point (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mirp_pkg::req_t   req,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  output logic             done,
  output mirp_pkg::res_t   res
);
  import mirp_pkg::*;

  typedef struct packed {
    logic signed [41:0] img_x;
    logic signed [41:0] img_y;
    logic signed [41:0] img_z;
    logic signed [42:0] d_x;
    logic signed [42:0] d_y;
    logic signed [42:0] d_z;
  } geo_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } pt_t;

  logic [15:0] side_epsilon;

  logic [ST_PATH:1] vld;
  logic [ST_PATH:3] okp;

  // pipeline never holds a request off
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      side_epsilon <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST_PATH-1:1], start & ~busy};
    end
  end

  logic signed [31:0] src_in [3];
  logic signed [31:0] ear_in [3];
  logic signed [15:0] nrm_in [3];

  always_comb begin
    src_in[0] = req.source_x;
    src_in[1] = req.source_y;
    src_in[2] = req.source_z;
    ear_in[0] = req.ear_x;
    ear_in[1] = req.ear_y;
    ear_in[2] = req.ear_z;
    nrm_in[0] = req.normal_x;
    nrm_in[1] = req.normal_y;
    nrm_in[2] = req.normal_z;
  end

  // stage 1: normal times each point
  logic signed [47:0] s1_ps [3];
  logic signed [47:0] s1_pe [3];
  logic signed [31:0] s1_off;
  logic signed [31:0] s1_src [3];
  logic signed [31:0] s1_ear [3];
  logic        [15:0] s1_nabs [3];
  logic               s1_nneg [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_ps[i]   <= $signed({{32{nrm_in[i][15]}}, nrm_in[i]})
                  * $signed({{16{src_in[i][31]}}, src_in[i]});
      s1_pe[i]   <= $signed({{32{nrm_in[i][15]}}, nrm_in[i]})
                  * $signed({{16{ear_in[i][31]}}, ear_in[i]});
      s1_src[i]  <= src_in[i];
      s1_ear[i]  <= ear_in[i];
      s1_nabs[i] <= nrm_in[i][15] ? 16'(~nrm_in[i] + 16'sd1) : nrm_in[i];
      s1_nneg[i] <= nrm_in[i][15];
    end
    s1_off <= req.plane_offset;
  end

  // stage 2: exact side distances with 30 fraction bits
  logic signed [49:0] s2_ss;
  logic signed [49:0] s2_se;
  logic signed [31:0] s2_src [3];
  logic signed [31:0] s2_ear [3];
  logic        [15:0] s2_nabs [3];
  logic               s2_nneg [3];
  logic signed [49:0] off_w;

  assign off_w = {{4{s1_off[31]}}, s1_off, 14'd0};

  always_ff @(posedge clk) begin
    s2_ss <= {{2{s1_ps[0][47]}}, s1_ps[0]} + {{2{s1_ps[1][47]}}, s1_ps[1]}
           + {{2{s1_ps[2][47]}}, s1_ps[2]} - off_w;
    s2_se <= {{2{s1_pe[0][47]}}, s1_pe[0]} + {{2{s1_pe[1][47]}}, s1_pe[1]}
           + {{2{s1_pe[2][47]}}, s1_pe[2]} - off_w;
    s2_src  <= s1_src;
    s2_ear  <= s1_ear;
    s2_nabs <= s1_nabs;
    s2_nneg <= s1_nneg;
  end

  // stage 3: side test and magnitudes
  logic signed [49:0] eps_w;
  logic               both_off;
  logic        [48:0] s3_as;
  logic        [48:0] s3_ae;
  logic               s3_ssneg;
  logic signed [31:0] s3_src [3];
  logic signed [31:0] s3_ear [3];
  logic        [15:0] s3_nabs [3];
  logic               s3_nneg [3];

  assign eps_w = $signed({20'd0, side_epsilon, 14'd0});
  assign both_off = (s2_ss > eps_w && s2_se > eps_w)
                 || (s2_ss < -eps_w && s2_se < -eps_w);

  always_ff @(posedge clk) begin
    okp[3]   <= both_off;
    s3_as    <= s2_ss[49] ? 49'(-s2_ss) : s2_ss[48:0];
    s3_ae    <= s2_se[49] ? 49'(-s2_se) : s2_se[48:0];
    s3_ssneg <= s2_ss[49];
    s3_src   <= s2_src;
    s3_ear   <= s2_ear;
    s3_nabs  <= s2_nabs;
    s3_nneg  <= s2_nneg;
  end

  always_ff @(posedge clk) begin
    okp[ST_PATH:4] <= okp[ST_PATH-1:3];
  end

  // stage 4: divisor and source side rounded to q20.16
  logic        [48:0] s4_num;
  logic        [49:0] s4_den;
  logic        [35:0] s4_ss16;
  logic               s4_ssneg;
  logic signed [31:0] s4_src [3];
  logic signed [31:0] s4_ear [3];
  logic        [15:0] s4_nabs [3];
  logic               s4_nneg [3];
  logic        [49:0] ss_rnd;

  assign ss_rnd = {1'b0, s3_as} + 50'd8192;

  always_ff @(posedge clk) begin
    s4_num   <= s3_as;
    s4_den   <= {1'b0, s3_as} + {1'b0, s3_ae};
    s4_ss16  <= ss_rnd[49:14];
    s4_ssneg <= s3_ssneg;
    s4_src   <= s3_src;
    s4_ear   <= s3_ear;
    s4_nabs  <= s3_nabs;
    s4_nneg  <= s3_nneg;
  end

  logic [16:0] quo;

  mirp_div u_div (
    .clk (clk),
    .num (s4_num),
    .den (s4_den),
    .quo (quo)
  );

  // stage 5: mirror offset magnitude
  logic        [51:0] s5_prd [3];
  logic               s5_neg [3];
  logic signed [31:0] s5_src [3];
  logic signed [31:0] s5_ear [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_prd[i] <= {36'd0, s4_nabs[i]} * {16'd0, s4_ss16};
      s5_neg[i] <= s4_nneg[i] ^ s4_ssneg;
    end
    s5_src <= s4_src;
    s5_ear <= s4_ear;
  end

  // stage 6: round normal * 2 * side / 2^14
  logic        [38:0] s6_rsm [3];
  logic               s6_neg [3];
  logic signed [31:0] s6_src [3];
  logic signed [31:0] s6_ear [3];
  logic        [51:0] prd_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd_rnd[i] = s5_prd[i] + 52'd4096;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s6_rsm[i] <= prd_rnd[i][51:13];
    end
    s6_neg <= s5_neg;
    s6_src <= s5_src;
    s6_ear <= s5_ear;
  end

  // stage 7: image point
  logic signed [41:0] s7_img [3];
  logic signed [31:0] s7_ear [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (s6_neg[i]) begin
        s7_img[i] <= {{10{s6_src[i][31]}}, s6_src[i]} + {3'd0, s6_rsm[i]};
      end else begin
        s7_img[i] <= {{10{s6_src[i][31]}}, s6_src[i]} - {3'd0, s6_rsm[i]};
      end
    end
    s7_ear <= s6_ear;
  end

  // stage 8: image to listener vector
  geo_t s8_geo;

  always_ff @(posedge clk) begin
    s8_geo.img_x <= s7_img[0];
    s8_geo.img_y <= s7_img[1];
    s8_geo.img_z <= s7_img[2];
    s8_geo.d_x   <= {{11{s7_ear[0][31]}}, s7_ear[0]} - {s7_img[0][41], s7_img[0]};
    s8_geo.d_y   <= {{11{s7_ear[1][31]}}, s7_ear[1]} - {s7_img[1][41], s7_img[1]};
    s8_geo.d_z   <= {{11{s7_ear[2][31]}}, s7_ear[2]} - {s7_img[2][41], s7_img[2]};
  end

  // geometry waits for the divider
  geo_t geo_line [9:ST_DIV_OUT];

  always_ff @(posedge clk) begin
    geo_line[9] <= s8_geo;
    for (int k = 10; k <= ST_DIV_OUT; k++) begin
      geo_line[k] <= geo_line[k-1];
    end
  end

  // point branch: fraction, scale, round, add, saturate
  logic signed [41:0] pimg_a [3];
  logic signed [42:0] pd_a [3];
  logic        [17:0] q_inc;

  always_comb begin
    pimg_a[0] = geo_line[ST_DIV_OUT].img_x;
    pimg_a[1] = geo_line[ST_DIV_OUT].img_y;
    pimg_a[2] = geo_line[ST_DIV_OUT].img_z;
    pd_a[0]   = geo_line[ST_DIV_OUT].d_x;
    pd_a[1]   = geo_line[ST_DIV_OUT].d_y;
    pd_a[2]   = geo_line[ST_DIV_OUT].d_z;
  end

  assign q_inc = {1'b0, quo} + 18'd1;

  logic        [16:0] p1_frac;
  logic signed [41:0] p1_img [3];
  logic signed [42:0] p1_d [3];

  always_ff @(posedge clk) begin
    p1_frac <= q_inc[17:1];
    p1_img  <= pimg_a;
    p1_d    <= pd_a;
  end

  logic signed [60:0] p2_m [3];
  logic signed [41:0] p2_img [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p2_m[i] <= $signed({{18{p1_d[i][42]}}, p1_d[i]}) * $signed({44'd0, p1_frac});
    end
    p2_img <= p1_img;
  end

  logic        [59:0] p3_abs [3];
  logic               p3_neg [3];
  logic signed [41:0] p3_img [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p3_abs[i] <= p2_m[i][60] ? 60'(-p2_m[i]) : p2_m[i][59:0];
      p3_neg[i] <= p2_m[i][60];
    end
    p3_img <= p2_img;
  end

  logic        [44:0] p4_rm [3];
  logic               p4_neg [3];
  logic signed [41:0] p4_img [3];
  logic        [60:0] abs_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_rnd[i] = {1'b0, p3_abs[i]} + 61'd32768;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p4_rm[i] <= abs_rnd[i][60:16];
    end
    p4_neg <= p3_neg;
    p4_img <= p3_img;
  end

  logic signed [45:0] p5_p [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (p4_neg[i]) begin
        p5_p[i] <= {{4{p4_img[i][41]}}, p4_img[i]} - {1'b0, p4_rm[i]};
      end else begin
        p5_p[i] <= {{4{p4_img[i][41]}}, p4_img[i]} + {1'b0, p4_rm[i]};
      end
    end
  end

  logic signed [31:0] sat_p [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p5_p[i] > 46'sd2147483647) begin
        sat_p[i] = 32'sh7FFF_FFFF;
      end else if (p5_p[i] < -46'sd2147483648) begin
        sat_p[i] = 32'sh8000_0000;
      end else begin
        sat_p[i] = p5_p[i][31:0];
      end
    end
  end

  // point waits for the path root
  pt_t pt_line [ST_POINT:ST_PATH];

  always_ff @(posedge clk) begin
    pt_line[ST_POINT].px <= sat_p[0];
    pt_line[ST_POINT].py <= sat_p[1];
    pt_line[ST_POINT].pz <= sat_p[2];
    for (int k = ST_POINT + 1; k <= ST_PATH; k++) begin
      pt_line[k] <= pt_line[k-1];
    end
  end

  // path branch: magnitudes, squares, sum, root
  logic signed [42:0] s8_d [3];
  logic        [31:0] s9_m [3];
  logic               s9_big;
  logic        [41:0] d_abs [3];

  always_comb begin
    s8_d[0] = s8_geo.d_x;
    s8_d[1] = s8_geo.d_y;
    s8_d[2] = s8_geo.d_z;
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = s8_d[i][42] ? 42'(-s8_d[i]) : s8_d[i][41:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s9_m[i] <= d_abs[i][31:0];
    end
    s9_big <= (|d_abs[0][41:32]) | (|d_abs[1][41:32]) | (|d_abs[2][41:32]);
  end

  logic [63:0] s10_sq [3];
  logic        s10_big;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s10_sq[i] <= {32'd0, s9_m[i]} * {32'd0, s9_m[i]};
    end
    s10_big <= s9_big;
  end

  logic [65:0] s11_sum;
  logic        s11_big;

  always_ff @(posedge clk) begin
    s11_sum <= {2'd0, s10_sq[0]} + {2'd0, s10_sq[1]} + {2'd0, s10_sq[2]};
    s11_big <= s10_big;
  end

  logic [31:0] path_root;

  mirp_sqrt u_sqrt (
    .clk  (clk),
    .rad  (s11_sum[63:0]),
    .sat  (s11_big | (|s11_sum[65:64])),
    .root (path_root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[ST_PATH];
    end
  end

  always_ff @(posedge clk) begin
    if (okp[ST_PATH]) begin
      res.valid_res   <= 1'b1;
      res.point_x     <= pt_line[ST_PATH].px;
      res.point_y     <= pt_line[ST_PATH].py;
      res.point_z     <= pt_line[ST_PATH].pz;
      res.path_length <= path_root;
    end else begin
      res <= '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mirp_chk.sv
// port level checks for the reflection point block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mirp_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire mirp_pkg::req_t req,
  input wire logic           done,
  input wire mirp_pkg::res_t res
);
  import mirp_pkg::*;

  // every result answers an accepted request
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // an invalid candidate reports all zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !res.valid_res) |-> (res.point_x == 0 && res.point_y == 0
                                  && res.point_z == 0 && res.path_length == 0))
    else $error("invalid result carries nonzero fields");

  // a zero normal with a zero offset leaves both points on the plane
  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    (done && res.valid_res) |-> $past(req.normal_x != 0 || req.normal_y != 0
                                      || req.normal_z != 0
                                      || req.plane_offset != 0, LATENCY))
    else $error("valid result from a degenerate plane");

  // reset flushes everything in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

bind mirror_image_reflection_point mirp_chk u_mirp_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .res   (res)
);

`default_nettype wire
